// File: rtl/core/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and constants for the watchdog timer register core.
// ----------------------------------------------------------------------------
package wdt_pkg;

   localparam int DATA_W = 32;

   // request actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // register selects
   localparam logic [2:0] SEL_LOAD   = 3'd0;
   localparam logic [2:0] SEL_VALUE  = 3'd1;
   localparam logic [2:0] SEL_CTRL   = 3'd2;
   localparam logic [2:0] SEL_CLEAR  = 3'd3;
   localparam logic [2:0] SEL_RIS    = 3'd4;
   localparam logic [2:0] SEL_MIS    = 3'd5;
   localparam logic [2:0] SEL_LOCK   = 3'd6;

   localparam logic [DATA_W-1:0] UNLOCK_KEY = 32'h1ACC_E551;

   // control register bit positions
   localparam int CTL_INTEN_BIT = 0;
   localparam int CTL_RESEN_BIT = 1;
   localparam int CTL_WRC_BIT   = 31;

   typedef struct packed {
      logic [1:0]        action;
      logic [2:0]        reg_select;
      logic [DATA_W-1:0] write_data;
   } wdt_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              interrupt_out;
      logic              reset_out;
   } wdt_rsp_type;

endpackage

// File: rtl/core/wdt_regs.sv
// ----------------------------------------------------------------------------
// wdt_regs
// Watchdog register file and down counter; applies one request per step and
// produces the matching response: read data from the pre-step state,
// interrupt and reset from the post-step state.
module wdt_regs import wdt_pkg::*; #(
   parameter int COUNTER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  wdt_req_type req,
   output wdt_rsp_type rsp
);

   logic [COUNTER_BITS-1:0] reload_value_ff, reload_value_in;
   logic [COUNTER_BITS-1:0] down_counter_ff, down_counter_in;
   logic                    int_enable_ff, int_enable_in;
   logic                    reset_enable_ff, reset_enable_in;
   logic                    raw_timeout_ff, raw_timeout_in;
   logic                    locked_ff, locked_in;
   logic                    reset_latched_ff, reset_latched_in;
   logic [DATA_W-1:0]       rd_data;

   always_comb begin
      reload_value_in  = reload_value_ff;
      down_counter_in  = down_counter_ff;
      int_enable_in    = int_enable_ff;
      reset_enable_in  = reset_enable_ff;
      raw_timeout_in   = raw_timeout_ff;
      locked_in        = locked_ff;
      reset_latched_in = reset_latched_ff;
      rd_data          = '0;

      case (req.action)
         ACT_TICK: begin
            if (int_enable_ff) begin
               if (down_counter_ff == '0) begin
                  // second timeout with status still pending
                  if (raw_timeout_ff && reset_enable_ff) begin
                     reset_latched_in = 1'b1;
                  end
                  raw_timeout_in  = 1'b1;
                  down_counter_in = reload_value_ff;
               end else begin
                  down_counter_in = down_counter_ff - 1'b1;
               end
            end
         end
         ACT_WRITE: begin
            if (req.reg_select == SEL_LOCK) begin
               locked_in = (req.write_data != UNLOCK_KEY);
            end else if (!locked_ff) begin
               unique case (req.reg_select)
                  SEL_LOAD: begin
                     reload_value_in = req.write_data[COUNTER_BITS-1:0];
                     down_counter_in = req.write_data[COUNTER_BITS-1:0];
                  end
                  SEL_CTRL: begin
                     if (req.write_data[CTL_INTEN_BIT]) begin
                        int_enable_in = 1'b1;
                     end
                     reset_enable_in = req.write_data[CTL_RESEN_BIT];
                  end
                  SEL_CLEAR: begin
                     raw_timeout_in  = 1'b0;
                     down_counter_in = reload_value_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ACT_READ: begin
            unique case (req.reg_select)
               SEL_LOAD:  rd_data = DATA_W'(reload_value_ff);
               SEL_VALUE: rd_data = DATA_W'(down_counter_ff);
               SEL_CTRL: begin
                  rd_data[CTL_WRC_BIT]   = 1'b1;
                  rd_data[CTL_INTEN_BIT] = int_enable_ff;
                  rd_data[CTL_RESEN_BIT] = reset_enable_ff;
               end
               SEL_RIS:   rd_data[0] = raw_timeout_ff;
               SEL_MIS:   rd_data[0] = raw_timeout_ff & int_enable_ff;
               SEL_LOCK:  rd_data[0] = locked_ff;
               default:   rd_data = '0;
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rsp.read_data     = rd_data;
   assign rsp.interrupt_out = raw_timeout_in & int_enable_in;
   assign rsp.reset_out     = reset_latched_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_value_ff  <= '1;
         down_counter_ff  <= '1;
         int_enable_ff    <= 1'b0;
         reset_enable_ff  <= 1'b0;
         raw_timeout_ff   <= 1'b0;
         locked_ff        <= 1'b0;
         reset_latched_ff <= 1'b0;
      end else if (step_en) begin
         reload_value_ff  <= reload_value_in;
         down_counter_ff  <= down_counter_in;
         int_enable_ff    <= int_enable_in;
         reset_enable_ff  <= reset_enable_in;
         raw_timeout_ff   <= raw_timeout_in;
         locked_ff        <= locked_in;
         reset_latched_ff <= reset_latched_in;
      end
   end

   a_reset_sticky: assert property (@(posedge clock) disable iff (reset)
      reset_latched_ff |=> reset_latched_ff)
      else $error("latched reset dropped");

   a_inten_sticky: assert property (@(posedge clock) disable iff (reset)
      int_enable_ff |=> int_enable_ff)
      else $error("interrupt enable cleared");

   a_reset_cause: assert property (@(posedge clock) disable iff (reset)
      !reset_latched_ff ##1 reset_latched_ff |->
         $past(raw_timeout_ff && reset_enable_ff && int_enable_ff))
      else $error("reset latched without pending timeout");

   a_lock_guard: assert property (@(posedge clock) disable iff (reset)
      step_en && locked_ff && req.action == ACT_WRITE && req.reg_select == SEL_LOAD
         |=> $stable(reload_value_ff))
      else $error("load written while locked");

endmodule

// File: rtl/core/watchdog_timer_registers_core.sv
// ----------------------------------------------------------------------------
// watchdog_timer_registers_core
// Path: an accepted request waits in the request register, then moves
// into the response register once the response slot is free or drains.
// Throughput: one request per cycle while the response side is not stalled,
// set by the single-pass register update.
// Reset: synchronous; counter and load go to all ones, all flags clear,
// block starts unlocked.
// ----------------------------------------------------------------------------
module watchdog_timer_registers_core import wdt_pkg::*; #(
   parameter int COUNTER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [2:0]        req_reg_select,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_interrupt_out,
   output logic              rsp_reset_out
);

   logic        req_valid_ff;
   wdt_req_type req_ff;
   logic        rsp_valid_ff;
   wdt_rsp_type rsp_ff;
   wdt_rsp_type rsp_next;
   logic        advance;

   // held request moves into the response register when that slot frees
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff.action     <= req_action;
         req_ff.reg_select <= req_reg_select;
         req_ff.write_data <= req_write_data;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   wdt_regs #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_interrupt_out = rsp_ff.interrupt_out;
   assign rsp_reset_out     = rsp_ff.reset_out;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the watchdog register core. Drives ticks and bus
// reads/writes through the request channel, predicts every response from a
// private model of the register file and counter, and checks each response
// field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
import wdt_pkg::*;

class wdt_scoreboard;
   localparam int CNT_BITS = 32;
   localparam logic [DATA_W-1:0] CNT_MASK = DATA_W'((64'd1 << CNT_BITS) - 64'd1);

   logic [DATA_W-1:0] load_val;
   logic [DATA_W-1:0] count_val;
   bit                int_en;
   bit                rst_en;
   bit                timeout_raw;
   bit                is_locked;
   bit                rst_latched;
   wdt_rsp_type       expected_rsp[$];
   int                mismatches;

   function void clear_state();
      load_val    = CNT_MASK;
      count_val   = CNT_MASK;
      int_en      = 1'b0;
      rst_en      = 1'b0;
      timeout_raw = 1'b0;
      is_locked   = 1'b0;
      rst_latched = 1'b0;
   endfunction

   function int pending();
      return expected_rsp.size();
   endfunction

   function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
   endfunction

   // Advance the register model by one accepted request, queue the response
   function void note_request(logic [1:0] act, logic [2:0] sel, logic [DATA_W-1:0] data);
      wdt_rsp_type rsp;
      rsp.read_data = '0;
      case (act)
         ACT_TICK: begin
            if (int_en) begin
               if (count_val == '0) begin
                  if (timeout_raw && rst_en) rst_latched = 1'b1;
                  timeout_raw = 1'b1;
                  count_val   = load_val;
               end else begin
                  count_val = (count_val - 1'b1) & CNT_MASK;
               end
            end
         end
         ACT_WRITE: begin
            if (sel == SEL_LOCK) begin
               is_locked = (data != UNLOCK_KEY);
            end else if (!is_locked) begin
               case (sel)
                  SEL_LOAD: begin
                     load_val  = data & CNT_MASK;
                     count_val = load_val;
                  end
                  SEL_CTRL: begin
                     if (data[CTL_INTEN_BIT]) int_en = 1'b1;
                     rst_en = data[CTL_RESEN_BIT];
                  end
                  SEL_CLEAR: begin
                     timeout_raw = 1'b0;
                     count_val   = load_val;
                  end
                  default: ;
               endcase
            end
         end
         ACT_READ: begin
            case (sel)
               SEL_LOAD:  rsp.read_data = load_val;
               SEL_VALUE: rsp.read_data = count_val;
               SEL_CTRL: begin
                  rsp.read_data[CTL_WRC_BIT]   = 1'b1;
                  rsp.read_data[CTL_INTEN_BIT] = int_en;
                  rsp.read_data[CTL_RESEN_BIT] = rst_en;
               end
               SEL_RIS:   rsp.read_data[0] = timeout_raw;
               SEL_MIS:   rsp.read_data[0] = timeout_raw & int_en;
               SEL_LOCK:  rsp.read_data[0] = is_locked;
               default: ;
            endcase
         end
         default: ;
      endcase
      rsp.interrupt_out = timeout_raw & int_en;
      rsp.reset_out     = rst_latched;
      expected_rsp.push_back(rsp);
   endfunction

   function void check_response(wdt_rsp_type got);
      wdt_rsp_type exp;
      if (expected_rsp.size() == 0) begin
         flag($sformatf("unexpected response data=%h irq=%b rst=%b",
                        got.read_data, got.interrupt_out, got.reset_out));
         return;
      end
      exp = expected_rsp.pop_front();
      if (got.read_data !== exp.read_data || got.interrupt_out !== exp.interrupt_out ||
          got.reset_out !== exp.reset_out)
         flag($sformatf("response exp data=%h irq=%b rst=%b, got data=%h irq=%b rst=%b",
                        exp.read_data, exp.interrupt_out, exp.reset_out,
                        got.read_data, got.interrupt_out, got.reset_out));
   endfunction
endclass

module tb;
   localparam int CNT_BITS       = 32;
   localparam int NUM_RANDOM     = 1000;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam logic [2:0] SEL_NONE = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_action = '0;
   logic [2:0]        req_reg_select = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_interrupt_out;
   logic              rsp_reset_out;

   wdt_scoreboard sb = new();
   bit            hold_req = 1'b0;
   bit            quiet = 1'b0;
   int            stall_cycles = 0;

   watchdog_timer_registers_core #(.COUNTER_BITS(CNT_BITS)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_reg_select    (req_reg_select),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_interrupt_out (rsp_interrupt_out),
      .rsp_reset_out     (rsp_reset_out)
   );

   always #4 clock = ~clock;

   task automatic send_request(input logic [1:0] act, input logic [2:0] sel,
                               input logic [DATA_W-1:0] data);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_reg_select <= sel;
      req_write_data <= data;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(act, sel, data);
   endtask

   // Mostly well-formed traffic: ticks, small reloads, clears and unlocks so
   // the counter actually times out; bit 1 of control stays low early on so
   // the reset latch is not hit right away.
   task automatic send_random(input int idx);
      logic [1:0]        act;
      logic [2:0]        sel;
      logic [DATA_W-1:0] data;
      int                pick;
      pick = $urandom_range(0, 99);
      data = $urandom;
      sel  = 3'($urandom_range(0, 7));
      if (pick < 45) act = ACT_TICK;
      else if (pick < 75) act = ACT_WRITE;
      else if (pick < 95) act = ACT_READ;
      else act = ACT_NONE;
      if (act == ACT_WRITE) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            sel  = SEL_LOAD;
            pick = $urandom_range(0, 9);
            if (pick < 7) data = $urandom_range(0, 15);
            else if (pick == 7) data = (pick[0]) ? '0 : '1;
            else if (pick == 8) data = '1;
         end else if (pick < 35) begin
            sel = SEL_CTRL;
            if (idx < NUM_RANDOM * 7 / 10) data[CTL_RESEN_BIT] = 1'b0;
         end else if (pick < 60) begin
            sel = SEL_CLEAR;
         end else if (pick < 75) begin
            sel = SEL_LOCK;
            if ($urandom_range(0, 3) != 0) data = UNLOCK_KEY;
         end
      end
      send_request(act, sel, data);
   endtask

   always @(posedge clock) begin
      wdt_rsp_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.read_data     = rsp_read_data;
         got.interrupt_out = rsp_interrupt_out;
         got.reset_out     = rsp_reset_out;
         sb.check_response(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side back-pressure
   initial begin
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            n = HOLD_CYCLES;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 20);
         end else begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 10);
         end
         repeat (n) @(posedge clock);
      end
   end

   initial begin
      sb.clear_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values, selector seven and clear read back as zero
      send_request(ACT_READ, SEL_LOAD, '0);
      send_request(ACT_READ, SEL_CTRL, '1);
      send_request(ACT_READ, SEL_LOCK, '0);
      send_request(ACT_READ, SEL_NONE, '0);
      send_request(ACT_READ, SEL_CLEAR, '0);
      // tick with interrupt enable clear must not count
      send_request(ACT_TICK, SEL_LOAD, '1);
      send_request(ACT_READ, SEL_VALUE, '0);
      // locked writes dropped, lock itself always writable
      send_request(ACT_WRITE, SEL_LOCK, '0);
      send_request(ACT_WRITE, SEL_LOAD, 32'h5);
      send_request(ACT_READ, SEL_LOAD, '0);
      send_request(ACT_WRITE, SEL_LOCK, UNLOCK_KEY);
      // read-only registers, unused select and unused action
      send_request(ACT_WRITE, SEL_VALUE, '0);
      send_request(ACT_WRITE, SEL_RIS, '1);
      send_request(ACT_WRITE, SEL_NONE, '1);
      send_request(ACT_NONE, SEL_NONE, '1);
      // timeout from zero load, then enable cannot be cleared
      send_request(ACT_WRITE, SEL_LOAD, '0);
      send_request(ACT_WRITE, SEL_CTRL, 32'h1);
      send_request(ACT_TICK, SEL_LOAD, '0);
      send_request(ACT_READ, SEL_MIS, '0);
      send_request(ACT_WRITE, SEL_CTRL, '0);
      send_request(ACT_WRITE, SEL_CLEAR, '1);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == 300) hold_req = 1'b1;
         if (i == 600) begin
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end else if (i >= NUM_RANDOM * 85 / 100) begin
            quiet = 1'b1;
         end else if ((i / 100) % 3 != 2 && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         send_random(i);
      end

      // missed interrupt latches the reset request; counting goes on
      send_request(ACT_WRITE, SEL_LOCK, UNLOCK_KEY);
      send_request(ACT_WRITE, SEL_LOAD, 32'h1);
      send_request(ACT_WRITE, SEL_CTRL, 32'h3);
      repeat (5) send_request(ACT_TICK, SEL_LOAD, '0);
      send_request(ACT_READ, SEL_VALUE, '0);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) sb.flag("responses missing at end of run");
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
